// ===== src/idle_gap_message_framer_defines.svh =====
// Assertion macros for the idle gap message framer.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef IDLE_GAP_MESSAGE_FRAMER_DEFINES_SVH
`define IDLE_GAP_MESSAGE_FRAMER_DEFINES_SVH

`ifndef SYNTHESIS

// cond must hold at every clock edge out of reset
`define IGMF_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("igmf assertion failed");

// ante implies cons in the same cycle
`define IGMF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("igmf implication failed");

`else

`define IGMF_ASSERT(lbl, cond)
`define IGMF_ASSERT_IMPL(lbl, ante, cons)

`endif

`endif

// ===== src/igmf_pkg.sv =====
// Shared constants and types of the idle gap message framer.
// No dependencies; imported by every igmf module except igmf_ram.
package igmf_pkg;

    localparam int BUFFER_SIZE = 64;
    localparam int IDX_W       = $clog2(BUFFER_SIZE);
    localparam int ADDR_W      = IDX_W + 1;          // bank bit + byte index
    localparam int RAM_DEPTH   = 2 ** ADDR_W;
    localparam int LEN_W       = 6;
    localparam int BYTE_W      = 8;
    localparam int TMR_W       = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [LEN_W-1:0] FULL_LEN   = LEN_W'(BUFFER_SIZE - 1);
    localparam logic [TMR_W-1:0] GAP_RESET  = 16'd10;
    localparam logic [TMR_W-1:0] HOLD_RESET = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAP_TIMEOUT  = 1'b0,
        CFG_HOLD_TIMEOUT = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_RECV = 3'b010,
        PH_HOLD = 3'b100
    } phase_t;

    // one closed message waiting in a bank of the store
    typedef struct packed {
        logic             bank;
        logic [LEN_W-1:0] len;
    } msg_desc_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } ram_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } ram_rd_t;

endpackage

// ===== src/igmf_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No package dependency.
module igmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/igmf_front.sv =====
// Front end: config registers, phase machine, gap/hold timers, store writes.
// Depends on igmf_pkg.
module igmf_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [igmf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [igmf_pkg::TMR_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           action,
    input  logic [igmf_pkg::BYTE_W-1:0]    rx_byte,
    input  logic                           frame_error,
    input  logic                           overrun_error,
    input  logic                           parity_error,
    input  logic                           q_full,
    output logic                           q_push,
    output igmf_pkg::msg_desc_t            q_desc,
    output igmf_pkg::ram_wr_t              ram_wr
);
    import igmf_pkg::*;

    logic [TMR_W-1:0] gap_timeout_reg, gap_timeout_next;
    logic [TMR_W-1:0] hold_timeout_reg, hold_timeout_next;
    phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0] byte_count_reg, byte_count_next;
    logic [TMR_W-1:0] gap_counter_reg, gap_counter_next;
    logic [TMR_W-1:0] hold_counter_reg, hold_counter_next;
    logic             bank_reg, bank_next;

    logic             accept;
    logic             err;
    logic             close_req;
    logic             store_req;
    logic [LEN_W-1:0] store_idx;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign err      = frame_error | overrun_error | parity_error;

    always_comb
    begin
        gap_timeout_next  = gap_timeout_reg;
        hold_timeout_next = hold_timeout_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_GAP_TIMEOUT:  gap_timeout_next  = cfg_data;
                CFG_HOLD_TIMEOUT: hold_timeout_next = cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        byte_count_next   = byte_count_reg;
        gap_counter_next  = gap_counter_reg;
        hold_counter_next = hold_counter_reg;
        bank_next         = bank_reg;
        close_req         = 1'b0;
        store_req         = 1'b0;
        store_idx         = byte_count_reg;

        if (accept)
        begin
            case (phase_reg)
                PH_RECV:
                begin
                    if (!action)
                    begin
                        if (gap_counter_reg <= TMR_W'(1))
                        begin
                            close_req = 1'b1;
                        end
                        else
                        begin
                            gap_counter_next = gap_counter_reg - TMR_W'(1);
                        end
                    end
                    else if (byte_count_reg >= FULL_LEN)
                    begin
                        close_req = 1'b1;   // full store: close, drop char
                    end
                    else if (err)
                    begin
                        byte_count_next  = '0;
                        gap_counter_next = '0;
                        phase_next       = PH_IDLE;
                    end
                    else
                    begin
                        store_req = 1'b1;
                    end
                end
                PH_HOLD:
                begin
                    if (!action)
                    begin
                        if (hold_counter_reg <= TMR_W'(1))
                        begin
                            hold_counter_next = '0;
                            phase_next        = PH_IDLE;
                        end
                        else
                        begin
                            hold_counter_next = hold_counter_reg - TMR_W'(1);
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    if (action && !err)
                    begin
                        store_req = 1'b1;
                        store_idx = '0;
                    end
                end
            endcase
        end

        if (store_req)
        begin
            byte_count_next  = store_idx + LEN_W'(1);
            gap_counter_next = gap_timeout_reg;
            phase_next       = PH_RECV;
        end

        if (close_req)
        begin
            byte_count_next   = '0;
            gap_counter_next  = '0;
            hold_counter_next = hold_timeout_reg;
            bank_next         = !bank_reg;
            phase_next        = (hold_timeout_reg == '0) ? PH_IDLE : PH_HOLD;
        end
    end

    assign q_push      = close_req;
    assign q_desc.bank = bank_reg;
    assign q_desc.len  = byte_count_reg;

    assign ram_wr.en   = store_req;
    assign ram_wr.addr = {bank_reg, store_idx[IDX_W-1:0]};
    assign ram_wr.data = rx_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_timeout_reg  <= GAP_RESET;
            hold_timeout_reg <= HOLD_RESET;
            phase_reg        <= PH_IDLE;
            byte_count_reg   <= '0;
            gap_counter_reg  <= '0;
            hold_counter_reg <= '0;
            bank_reg         <= 1'b0;
        end
        else
        begin
            gap_timeout_reg  <= gap_timeout_next;
            hold_timeout_reg <= hold_timeout_next;
            phase_reg        <= phase_next;
            byte_count_reg   <= byte_count_next;
            gap_counter_reg  <= gap_counter_next;
            hold_counter_reg <= hold_counter_next;
            bank_reg         <= bank_next;
        end
    end

endmodule

// ===== src/igmf_queue.sv =====
// Two-entry queue of closed-message descriptors between front and back.
// Depends on igmf_pkg.
module igmf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  igmf_pkg::msg_desc_t push_desc,
    input  logic                pop,
    output logic                full,
    output logic                not_empty,
    output igmf_pkg::msg_desc_t head
);
    import igmf_pkg::*;

    msg_desc_t         ent_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/igmf_back.sv =====
// Back end: walks a closed message in the store, one byte per read, into
// the output register. Depends on igmf_pkg.
module igmf_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_not_empty,
    input  igmf_pkg::msg_desc_t         q_head,
    output logic                        q_pop,
    output igmf_pkg::ram_rd_t           ram_rd,
    input  logic [igmf_pkg::BYTE_W-1:0] ram_rd_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [igmf_pkg::BYTE_W-1:0] msg_byte,
    output logic [igmf_pkg::LEN_W-1:0]  msg_length,
    output logic                        msg_last
);
    import igmf_pkg::*;

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic              pend_last_reg, pend_last_next;
    logic [LEN_W-1:0]  pend_len_reg, pend_len_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              last_reg, last_next;

    logic issue;
    logic is_last;

    // read only when the output register is free by the time data lands
    assign issue   = q_not_empty && !pend_reg && (!out_valid_reg || !out_stall);
    assign is_last = (LEN_W'(idx_reg) + LEN_W'(1)) == q_head.len;

    assign q_pop       = issue && is_last;
    assign ram_rd.en   = issue;
    assign ram_rd.addr = {q_head.bank, idx_reg};

    always_comb
    begin
        idx_next       = idx_reg;
        pend_next      = issue;
        pend_last_next = pend_last_reg;
        pend_len_next  = pend_len_reg;
        out_valid_next = out_valid_reg;
        byte_next      = byte_reg;
        len_next       = len_reg;
        last_next      = last_reg;

        if (issue)
        begin
            idx_next       = is_last ? '0 : idx_reg + IDX_W'(1);
            pend_last_next = is_last;
            pend_len_next  = q_head.len;
        end

        if (pend_reg)
        begin
            out_valid_next = 1'b1;
            byte_next      = ram_rd_data;
            len_next       = pend_len_reg;
            last_next      = pend_last_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign msg_byte   = byte_reg;
    assign msg_length = len_reg;
    assign msg_last   = last_reg;

    always_ff @(posedge clk)
    begin
        pend_last_reg <= pend_last_next;
        pend_len_reg  <= pend_len_next;
        byte_reg      <= byte_next;
        len_reg       <= len_next;
        last_reg      <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== src/idle_gap_message_framer.sv =====
// Channel  | Dir | Handshake               | Beat
// ---------+-----+-------------------------+----------------------------------------
// input    | in  | in_valid / in_stall     | action, rx_byte, error flags
// output   | out | out_valid / out_stall   | msg_byte, msg_length, msg_last
// config   | in  | cfg_valid / cfg_ready   | cfg_index, cfg_data (16 bit)
//
// Every input beat (tick or character) is handled by the front end as it is accepted.
// A closed message drains byte by byte, and the back end waits for each registered read to
// land before it issues the next; a stalled output register also holds the reads.
// The store holds two banks; input stalls only while two closed messages wait.
// Reset is asynchronous and clears control only; store needs no clearing pass.
// Config writes are always taken (cfg_ready tied high).
`include "idle_gap_message_framer_defines.svh"

module idle_gap_message_framer (
    input  logic                           clk,
    input  logic                           rst_n,
    // config write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [igmf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [igmf_pkg::TMR_W-1:0]     cfg_data,
    // input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           action,
    input  logic [igmf_pkg::BYTE_W-1:0]    rx_byte,
    input  logic                           frame_error,
    input  logic                           overrun_error,
    input  logic                           parity_error,
    // output channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [igmf_pkg::BYTE_W-1:0]    msg_byte,
    output logic [igmf_pkg::LEN_W-1:0]     msg_length,
    output logic                           msg_last
);
    import igmf_pkg::*;

    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_not_empty;
    msg_desc_t         q_push_desc;
    msg_desc_t         q_head;
    ram_wr_t           ram_wr;
    ram_rd_t           ram_rd;
    logic [BYTE_W-1:0] ram_rd_data;

    assign cfg_ready = 1'b1;

    // front: classifies beats, runs the timers, writes the current bank
    igmf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .rx_byte       (rx_byte),
        .frame_error   (frame_error),
        .overrun_error (overrun_error),
        .parity_error  (parity_error),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_desc        (q_push_desc),
        .ram_wr        (ram_wr)
    );

    // closed messages waiting for the back end; an entry is held until its
    // last byte has been read, so it also marks its bank as busy
    igmf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (q_push_desc),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // message store: two banks of BUFFER_SIZE bytes, bank bit on top
    igmf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr.en),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_en   (ram_rd.en),
        .rd_addr (ram_rd.addr),
        .rd_data (ram_rd_data)
    );

    // back: reads the head message byte by byte into the output register
    igmf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .ram_rd      (ram_rd),
        .ram_rd_data (ram_rd_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .msg_byte    (msg_byte),
        .msg_length  (msg_length),
        .msg_last    (msg_last)
    );

    // a message never closes while both banks are taken
    `IGMF_ASSERT_IMPL(a_push_not_full, q_push, !q_full)
    // front writes and back reads never touch the same bank
    `IGMF_ASSERT_IMPL(a_bank_split, ram_wr.en && ram_rd.en,
                      ram_wr.addr[ADDR_W-1] != ram_rd.addr[ADDR_W-1])
    // a queued message is never empty
    `IGMF_ASSERT_IMPL(a_head_len, q_not_empty, q_head.len != '0)

endmodule

// ===== tb/sv/idle_gap_message_framer_tb.sv =====
// Self-checking testbench for idle_gap_message_framer: a directed table, then random traffic.
// Depends on igmf_pkg and the framer RTL; expected bytes come from a predictor kept in here.
module idle_gap_message_framer_tb;
    import igmf_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int MAX_REPORTS = 10;

    // error flag triples, ordered {frame, overrun, parity}
    localparam logic [2:0] ERR_NONE    = 3'b000;
    localparam logic [2:0] ERR_FRAME   = 3'b100;
    localparam logic [2:0] ERR_OVERRUN = 3'b010;
    localparam logic [2:0] ERR_PARITY  = 3'b001;

    typedef enum logic {
        ACT_TICK = 1'b0,
        ACT_CHAR = 1'b1
    } uart_action_t;

    // one input beat: a time tick or a received character
    typedef struct packed {
        uart_action_t      action;
        logic [BYTE_W-1:0] data;
        logic              frame_err;
        logic              overrun_err;
        logic              parity_err;
    } uart_beat_t;

    // one output beat: a byte of a closed message
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic              last;
    } msg_beat_t;

    // directed table row: either a register write or an input beat
    typedef struct {
        bit                is_cfg;
        cfg_reg_t          reg_sel;
        logic [TMR_W-1:0]  reg_val;
        uart_beat_t        beat;
        bit                typed;       // expected outcome written into the row
        int                typed_n;     // number of bytes the beat closes out
        logic [BYTE_W-1:0] typed_byte;  // the byte, for a one-byte message
    } stim_row_t;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    cfg_reg_t          cfg_index;
    logic [TMR_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic              action;
    logic [BYTE_W-1:0] rx_byte;
    logic              frame_error;
    logic              overrun_error;
    logic              parity_error;
    logic              out_valid;
    logic              out_stall;
    logic [BYTE_W-1:0] msg_byte;
    logic [LEN_W-1:0]  msg_length;
    logic              msg_last;

    idle_gap_message_framer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .rx_byte       (rx_byte),
        .frame_error   (frame_error),
        .overrun_error (overrun_error),
        .parity_error  (parity_error),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .msg_byte      (msg_byte),
        .msg_length    (msg_length),
        .msg_last      (msg_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Framer predictor: register copies, framing state and the message store
    // ------------------------------------------------------------------
    logic [TMR_W-1:0]  gap_cfg;
    logic [TMR_W-1:0]  hold_cfg;
    phase_t            fr_phase;
    logic [LEN_W-1:0]  fr_count;
    logic [TMR_W-1:0]  gap_left;
    logic [TMR_W-1:0]  hold_left;
    logic [BYTE_W-1:0] fr_store [BUFFER_SIZE];
    msg_beat_t         pending_bytes[$];   // bytes the block still owes us
    int                last_emitted;       // bytes closed out by the latest beat

    // bookkeeping shared by the processes
    int fail_count    = 0;
    int cycle_count   = 0;
    int beats_sent    = 0;
    int src_idle_pct  = 0;
    int snk_idle_pct  = 0;
    int hold_off_req  = 0;   // main asks for a long receiver hold-off here
    int hold_off_left = 0;

    function automatic void flag_error(string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, what);
    endfunction

    // Closing a message queues every stored byte; the last one is marked.
    function automatic void emit_message();
        msg_beat_t m;
        for (int k = 0; k < int'(fr_count); k++)
        begin
            m.data = fr_store[k];
            m.len  = fr_count;
            m.last = (k + 1 == int'(fr_count));
            pending_bytes.push_back(m);
        end
        last_emitted = int'(fr_count);
        fr_count     = '0;
        gap_left     = '0;
        hold_left    = hold_cfg;
        fr_phase     = (hold_cfg == '0) ? PH_IDLE : PH_HOLD;
    endfunction

    function automatic void store_char(logic [BYTE_W-1:0] d);
        fr_store[fr_count] = d;
        fr_count           = fr_count + 1'b1;
        gap_left           = gap_cfg;   // zero behaves as one: next tick closes
        fr_phase           = PH_RECV;
    endfunction

    function automatic void frame_predict(uart_beat_t b);
        logic bad;
        bad          = b.frame_err | b.overrun_err | b.parity_err;
        last_emitted = 0;
        case (fr_phase)
            PH_RECV:
            begin
                if (b.action == ACT_TICK)
                begin
                    if (gap_left <= 1)
                        emit_message();
                    else
                        gap_left = gap_left - 1'b1;
                end
                else if (fr_count >= FULL_LEN)
                    emit_message();          // full store: the character is lost, flags or not
                else if (bad)
                begin
                    fr_count = '0;           // error throws away the partial message
                    gap_left = '0;
                    fr_phase = PH_IDLE;
                end
                else
                    store_char(b.data);
            end
            PH_HOLD:
            begin
                // characters are dropped here and do not touch the hold count
                if (b.action == ACT_TICK)
                begin
                    if (hold_left <= 1)
                    begin
                        hold_left = '0;
                        fr_phase  = PH_IDLE;
                    end
                    else
                        hold_left = hold_left - 1'b1;
                end
            end
            default:
            begin
                fr_phase = PH_IDLE;
                if (b.action == ACT_CHAR && !bad)
                begin
                    fr_count = '0;
                    store_char(b.data);
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Beat builders
    // ------------------------------------------------------------------
    function automatic uart_beat_t char_beat(logic [BYTE_W-1:0] d, logic [2:0] flags);
        uart_beat_t b;
        b.action      = ACT_CHAR;
        b.data        = d;
        b.frame_err   = flags[2];
        b.overrun_err = flags[1];
        b.parity_err  = flags[0];
        return b;
    endfunction

    // tick payload bits are don't-care, so they are scrambled
    function automatic uart_beat_t tick_beat();
        uart_beat_t b;
        b        = char_beat(8'($urandom_range(255)), 3'($urandom_range(7)));
        b.action = ACT_TICK;
        return b;
    endfunction

    function automatic uart_beat_t noise_beat();
        uart_beat_t b;
        b.action      = uart_action_t'($urandom_range(1));
        b.data        = 8'($urandom_range(255));
        b.frame_err   = ($urandom_range(5) == 0);
        b.overrun_err = ($urandom_range(5) == 0);
        b.parity_err  = ($urandom_range(5) == 0);
        return b;
    endfunction

    function automatic stim_row_t beat_row(uart_action_t act, logic [BYTE_W-1:0] d,
                                           logic [2:0] flags, bit typed, int n,
                                           logic [BYTE_W-1:0] tb_byte);
        stim_row_t r;
        r.is_cfg     = 1'b0;
        r.reg_sel    = CFG_GAP_TIMEOUT;
        r.reg_val    = '0;
        r.beat       = char_beat(d, flags);
        r.beat.action = act;
        r.typed      = typed;
        r.typed_n    = n;
        r.typed_byte = tb_byte;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(cfg_reg_t sel, logic [TMR_W-1:0] val);
        stim_row_t r;
        r         = beat_row(ACT_TICK, 8'h00, ERR_NONE, 1'b0, 0, 8'h00);
        r.is_cfg  = 1'b1;
        r.reg_sel = sel;
        r.reg_val = val;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input side. Valid is raised at a clock edge and held, payload unchanged,
    // until an edge sees stall low. in_stall is read right after the edge, so
    // it is the value the DUT saw at that edge.
    // ------------------------------------------------------------------
    task automatic send_beat(uart_beat_t b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        action        <= b.action;
        rx_byte       <= b.data;
        frame_error   <= b.frame_err;
        overrun_error <= b.overrun_err;
        parity_error  <= b.parity_err;
        do @(posedge clk); while (in_stall);
        frame_predict(b);
        beats_sent++;
    endtask

    // drop valid and move past the edge so the next raise lands in a new step
    task automatic idle_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Tick the framer back to idle; if noisy, some characters are thrown in
    // during hold to show they get dropped.
    task automatic run_out(bit noisy);
        while (fr_phase != PH_IDLE)
        begin
            if (noisy && fr_phase == PH_HOLD && $urandom_range(3) == 0)
                send_beat(char_beat(8'($urandom_range(255)), 3'($urandom_range(7))));
            send_beat(tick_beat());
        end
    endtask

    // Registers only change with the framer idle and nothing owed; the extra
    // cycles cover a beat still in flight that produces no output.
    task automatic write_reg(cfg_reg_t sel, logic [TMR_W-1:0] val);
        run_out(1'b0);
        idle_input();
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (sel == CFG_GAP_TIMEOUT)
            gap_cfg = val;
        else
            hold_cfg = val;
        @(posedge clk);
    endtask

    // Mostly well-formed messages with random content: start from idle, stream
    // characters (sometimes with ticks short of the gap between them), then
    // close by gap, by a full store, or break it with an error character.
    // About three in ten of the calls are just loose noise beats.
    task automatic send_message_sequence();
        int pick;
        int len;
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            repeat ($urandom_range(1, 4)) send_beat(noise_beat());
            return;
        end
        run_out(1'b1);
        len = (pick < 85) ? $urandom_range(1, 8) :
              (pick < 95) ? $urandom_range(9, 62) : BUFFER_SIZE - 1;
        for (int i = 0; i < len; i++)
        begin
            if (i > 0 && gap_left > 2 && $urandom_range(3) == 0)
                repeat ($urandom_range(1, gap_left - 2)) send_beat(tick_beat());
            send_beat(char_beat(8'($urandom_range(255)), ERR_NONE));
        end
        if (len == BUFFER_SIZE - 1)
            send_beat(char_beat(8'($urandom_range(255)), 3'($urandom_range(7))));
        else if ($urandom_range(9) == 0)
            send_beat(char_beat(8'($urandom_range(255)), 3'($urandom_range(1, 7))));
        run_out(1'b1);
    endtask

    // ------------------------------------------------------------------
    // Output side: check each accepted beat against the oldest owed byte,
    // then decide the stall for the next cycle. A requested hold-off is
    // counted down here, independent of what the sender is doing.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        msg_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_bytes.size() == 0)
                flag_error($sformatf("unexpected beat: byte %02h len %0d last %0b",
                                     msg_byte, msg_length, msg_last));
            else
            begin
                want = pending_bytes.pop_front();
                if (msg_byte !== want.data || msg_length !== want.len ||
                    msg_last !== want.last)
                    flag_error($sformatf({"exp byte %02h len %0d last %0b, ",
                                          "got byte %02h len %0d last %0b"},
                                         want.data, want.len, want.last,
                                         msg_byte, msg_length, msg_last));
            end
        end
        if (hold_off_req > 0)
        begin
            hold_off_left = hold_off_req;
            hold_off_req  = 0;
        end
        if (hold_off_left > 0)
        begin
            hold_off_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < snk_idle_pct);
    end

    // watchdog, far above the slowest legal run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        stim_row_t rows[$];
        msg_beat_t got;

        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_GAP_TIMEOUT;
        cfg_data      = '0;
        in_valid      = 1'b0;
        action        = ACT_TICK;
        rx_byte       = '0;
        frame_error   = 1'b0;
        overrun_error = 1'b0;
        parity_error  = 1'b0;
        out_stall     = 1'b0;

        gap_cfg   = GAP_RESET;
        hold_cfg  = HOLD_RESET;
        fr_phase  = PH_IDLE;
        fr_count  = '0;
        gap_left  = '0;
        hold_left = '0;

        // sender idles rarely, receiver often
        src_idle_pct = 9;
        snk_idle_pct = 58;

        // reset values first: a tick in idle and bad first characters do nothing
        rows.push_back(beat_row(ACT_TICK, 8'h00, ERR_NONE,    1'b1, 0, 8'h00));
        rows.push_back(beat_row(ACT_CHAR, 8'hFF, ERR_FRAME,   1'b1, 0, 8'h00));
        rows.push_back(beat_row(ACT_CHAR, 8'h80, ERR_OVERRUN, 1'b1, 0, 8'h00));
        // gap of zero acts as one; no hold at all
        rows.push_back(cfg_row(CFG_GAP_TIMEOUT,  16'd0));
        rows.push_back(cfg_row(CFG_HOLD_TIMEOUT, 16'd0));
        rows.push_back(beat_row(ACT_CHAR, 8'h00, ERR_NONE,    1'b1, 0, 8'h00));
        rows.push_back(beat_row(ACT_TICK, 8'h00, ERR_NONE,    1'b1, 1, 8'h00));
        rows.push_back(beat_row(ACT_CHAR, 8'hFF, ERR_NONE,    1'b1, 0, 8'h00));
        rows.push_back(beat_row(ACT_TICK, 8'hFF, ERR_PARITY,  1'b1, 1, 8'hFF));
        // error mid-message throws the partial message away
        rows.push_back(cfg_row(CFG_GAP_TIMEOUT,  16'd1));
        rows.push_back(beat_row(ACT_CHAR, 8'h5A, ERR_NONE,    1'b1, 0, 8'h00));
        rows.push_back(beat_row(ACT_CHAR, 8'hA5, ERR_OVERRUN, 1'b1, 0, 8'h00));
        rows.push_back(beat_row(ACT_TICK, 8'h00, ERR_NONE,    1'b1, 0, 8'h00));
        rows.push_back(beat_row(ACT_CHAR, 8'h3C, ERR_NONE,    1'b1, 0, 8'h00));
        rows.push_back(beat_row(ACT_TICK, 8'h00, ERR_NONE,    1'b1, 1, 8'h3C));
        // two-byte message, then a short hold with characters refused
        rows.push_back(cfg_row(CFG_GAP_TIMEOUT,  16'd3));
        rows.push_back(cfg_row(CFG_HOLD_TIMEOUT, 16'd2));
        rows.push_back(beat_row(ACT_CHAR, 8'h81, ERR_NONE,    1'b0, 0, 8'h00));
        rows.push_back(beat_row(ACT_CHAR, 8'h7E, ERR_NONE,    1'b0, 0, 8'h00));
        rows.push_back(beat_row(ACT_TICK, 8'h00, ERR_NONE,    1'b0, 0, 8'h00));
        rows.push_back(beat_row(ACT_TICK, 8'h00, ERR_NONE,    1'b0, 0, 8'h00));
        rows.push_back(beat_row(ACT_TICK, 8'h00, ERR_NONE,    1'b0, 0, 8'h00));
        rows.push_back(beat_row(ACT_CHAR, 8'h11, ERR_NONE,    1'b1, 0, 8'h00));
        rows.push_back(beat_row(ACT_TICK, 8'h00, ERR_NONE,    1'b1, 0, 8'h00));
        rows.push_back(beat_row(ACT_CHAR, 8'h22, ERR_PARITY,  1'b1, 0, 8'h00));
        rows.push_back(beat_row(ACT_TICK, 8'h00, ERR_NONE,    1'b1, 0, 8'h00));
        rows.push_back(beat_row(ACT_CHAR, 8'h0F, ERR_NONE,    1'b1, 0, 8'h00));
        rows.push_back(beat_row(ACT_CHAR, 8'hF0, ERR_PARITY,  1'b1, 0, 8'h00));
        rows.push_back(beat_row(ACT_TICK, 8'h00, ERR_NONE,    1'b1, 0, 8'h00));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; typed rows also cross-check the predictor itself
        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
                write_reg(rows[i].reg_sel, rows[i].reg_val);
            else
            begin
                send_beat(rows[i].beat);
                if (rows[i].typed)
                begin
                    if (last_emitted != rows[i].typed_n)
                        flag_error($sformatf("row %0d: %0d bytes closed, table says %0d",
                                             i, last_emitted, rows[i].typed_n));
                    else if (last_emitted == 1)
                    begin
                        got = pending_bytes[$];
                        if (got.data !== rows[i].typed_byte || got.len !== 1 ||
                            got.last !== 1'b1)
                            flag_error($sformatf("row %0d: byte %02h, table says %02h",
                                                 i, got.data, rows[i].typed_byte));
                    end
                end
            end
        end

        // moderate gap and hold; midway the sender waits for every owed byte
        write_reg(CFG_GAP_TIMEOUT,  16'd4);
        write_reg(CFG_HOLD_TIMEOUT, 16'd3);
        beats_sent = 0;
        while (beats_sent < 40)
            send_message_sequence();
        idle_input();
        while (pending_bytes.size() != 0)
            @(posedge clk);
        while (beats_sent < 80)
            send_message_sequence();

        // idle roles swapped; smallest gap and no hold so messages close fast.
        // A long receiver hold-off fills both store banks and stalls the input.
        src_idle_pct = 58;
        snk_idle_pct = 9;
        write_reg(CFG_GAP_TIMEOUT,  16'd1);
        write_reg(CFG_HOLD_TIMEOUT, 16'd0);
        hold_off_req = 400;
        while (beats_sent < 140)
            send_message_sequence();

        // no idling from here on. Largest gap: only a full store can close.
        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_reg(CFG_GAP_TIMEOUT,  16'hFFFF);
        write_reg(CFG_HOLD_TIMEOUT, 16'd0);
        repeat (BUFFER_SIZE - 1)
            send_beat(char_beat(8'($urandom_range(255)), ERR_NONE));
        send_beat(char_beat(8'($urandom_range(255)), 3'($urandom_range(1, 7))));

        // largest hold: one message, then traffic that the hold swallows
        write_reg(CFG_GAP_TIMEOUT,  16'($urandom_range(2, 5)));
        write_reg(CFG_HOLD_TIMEOUT, 16'hFFFF);
        repeat (3)
            send_beat(char_beat(8'($urandom_range(255)), ERR_NONE));
        while (fr_phase == PH_RECV)
            send_beat(tick_beat());
        repeat (12)
            send_beat(noise_beat());

        // drain, then leave room for anything stray
        idle_input();
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/igmf_pkg.sv
src/igmf_ram.sv
src/igmf_front.sv
src/igmf_queue.sv
src/igmf_back.sv
src/idle_gap_message_framer.sv
tb/sv/idle_gap_message_framer_tb.sv
